// File: rtl/bbc_pkg.sv
// ============================================================================
// bbc_pkg : shared types and constants of the bracket balance checker
// Holds the bracket characters, the two-bit bracket codes, the operation
// word that passes from the front end to the stack engine, and the
// classification function.
// ============================================================================
package bbc_pkg;

    // Bracket characters, as raw bytes.
    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28; // '('
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29; // ')'
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B; // '['
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D; // ']'
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B; // '{'
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D; // '}'

    // Two-bit code of a bracket kind, as it is held on the stack.
    typedef logic [1:0] t_code;

    localparam t_code CODE_NONE   = 2'd0;
    localparam t_code CODE_ROUND  = 2'd1;
    localparam t_code CODE_CURLY  = 2'd2;
    localparam t_code CODE_SQUARE = 2'd3;

    // What the stack engine has to do with one character.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PUSH,
        KIND_POP
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_code code;
        logic  last;
    } t_op;

    // Turns one character into a stack operation.
    function automatic t_op classify(input logic [7:0] ch, input logic last);
        t_op op;
        op.last = last;
        case (ch)
            CH_OPEN_ROUND: begin
                op.kind = KIND_PUSH;
                op.code = CODE_ROUND;
            end
            CH_OPEN_CURLY: begin
                op.kind = KIND_PUSH;
                op.code = CODE_CURLY;
            end
            CH_OPEN_SQUARE: begin
                op.kind = KIND_PUSH;
                op.code = CODE_SQUARE;
            end
            CH_CLOSE_ROUND: begin
                op.kind = KIND_POP;
                op.code = CODE_ROUND;
            end
            CH_CLOSE_CURLY: begin
                op.kind = KIND_POP;
                op.code = CODE_CURLY;
            end
            CH_CLOSE_SQUARE: begin
                op.kind = KIND_POP;
                op.code = CODE_SQUARE;
            end
            default: begin
                op.kind = KIND_NONE;
                op.code = CODE_NONE;
            end
        endcase
        return op;
    endfunction

endpackage

// File: rtl/bbc_ifs.sv
// ============================================================================
// bbc_ifs : valid/ready channels of the bracket balance checker
// One interface for the character stream and one for the verdicts.
// ============================================================================
interface bbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface bbc_out_if;
    logic valid;
    logic ready;
    logic balanced;
    logic overflowed;

    modport source (output valid, output balanced, output overflowed, input ready);
    modport sink   (input valid, input balanced, input overflowed, output ready);
endinterface

// File: rtl/bbc_front.sv
// ============================================================================
// bbc_front : input stage of the bracket balance checker
// Takes character words while the queue has room and classifies each one
// into a push, a pop or nothing before it is queued.
// ============================================================================
module bbc_front
    import bbc_pkg::*;
(
    bbc_in_if.sink i_in,
    input  logic   i_q_full,
    output logic   o_q_wr,
    output t_op    o_q_op
);

    assign i_in.ready = !i_q_full;
    assign o_q_wr     = i_in.valid && !i_q_full;
    assign o_q_op     = classify(i_in.ch, i_in.last);

endmodule

// File: rtl/bbc_queue.sv
// ============================================================================
// bbc_queue : two-entry operation queue
// Decouples the input stage from the stack engine so that a stall on either
// side holds up the other only once the queue has filled or run empty.
// ============================================================================
module bbc_queue
    import bbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_op  i_wr_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op,
    input  logic i_rd
);

    t_op        r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (i_rd) begin
            n_rd_ptr = !r_rd_ptr;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 2'd1;
        end else if (i_rd && !i_wr) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wr_ptr] <= i_wr_op;
        end
    end

endmodule

// File: rtl/bbc_back.sv
// ============================================================================
// bbc_back : stack engine of the bracket balance checker
// Carries out one queued operation per cycle on the bracket stack (one that
// ends a string waits for a free output register) and holds verdicts there.
// ============================================================================
module bbc_back
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_op        i_q_op,
    output logic       o_q_rd,
    bbc_out_if.source  o_out
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // The memory holds the whole stack; the top entry is also kept in
    // r_top, and r_below always holds the entry under it, read ahead.
    t_code          r_stack [STACK_DEPTH];
    t_code          r_top;
    t_code          r_below;
    logic [LW-1:0]  r_level;
    logic           r_failed;
    logic           r_ovf;
    logic           r_out_valid;
    logic           r_balanced;
    logic           r_overflowed;

    logic [LW-1:0]  n_level;
    logic           n_failed;
    logic           n_ovf;
    t_code          n_top;
    logic           mem_we;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;
    logic           out_free;
    logic           res_balanced;
    logic           res_overflowed;
    logic [LW-1:0]  level_m2;

    assign out_free = !r_out_valid || o_out.ready;
    assign o_q_rd   = i_q_valid && (!i_q_op.last || out_free);
    assign wr_addr  = r_level[AW-1:0];

    always_comb begin
        n_level  = r_level;
        n_failed = r_failed;
        n_ovf    = r_ovf;
        n_top    = r_top;
        mem_we   = 1'b0;
        if (o_q_rd && !r_failed) begin
            case (i_q_op.kind)
                KIND_PUSH: begin
                    if (r_level == LW'(STACK_DEPTH)) begin
                        n_failed = 1'b1;
                        n_ovf    = 1'b1;
                    end else begin
                        mem_we  = 1'b1;
                        n_top   = i_q_op.code;
                        n_level = r_level + LW'(1);
                    end
                end
                KIND_POP: begin
                    if (r_level == '0 || r_top != i_q_op.code) begin
                        n_failed = 1'b1;
                    end else begin
                        n_level = r_level - LW'(1);
                        n_top   = r_below;
                    end
                end
                default: begin
                end
            endcase
        end
        res_balanced   = !n_failed && (n_level == '0);
        res_overflowed = n_ovf;
        if (o_q_rd && i_q_op.last) begin
            n_level  = '0;
            n_failed = 1'b0;
            n_ovf    = 1'b0;
        end
        level_m2 = n_level - LW'(2);
        rd_addr  = level_m2[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_failed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_level  <= n_level;
            r_failed <= n_failed;
            r_ovf    <= n_ovf;
            if (o_q_rd && i_q_op.last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (o_q_rd && i_q_op.last) begin
            r_balanced   <= res_balanced;
            r_overflowed <= res_overflowed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[wr_addr] <= i_q_op.code;
        end
        r_below <= r_stack[rd_addr];
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.balanced   = r_balanced;
    assign o_out.overflowed = r_overflowed;

    a_level_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_ovf_failed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_failed)
        else $error("overflow seen without failure");

    a_last_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_rd && i_q_op.last) |=> (r_level == '0 && !r_failed && !r_ovf))
        else $error("string state not cleared after last word");

    a_frozen : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_failed && !(o_q_rd && i_q_op.last)) |=> $stable(r_level))
        else $error("stack moved after failure");

endmodule

// File: rtl/bracket_balance_checker_top.sv
// The verdict of a string appears on o_out after its last word is accepted: that word is
// queued first, and the engine registers the verdict when it takes the word.
// Throughput: one character word per cycle while the verdict register is free, set
// by the engine's single stack push or pop per cycle on registered top and below entries.
// Reset is synchronous and active low; it clears the fill level, flags and queue.
// The stack memory is not cleared; only entries written since reset are used.
// ============================================================================
// bracket_balance_checker_top : streaming bracket balance checker
// Checks that round, curly and square brackets in a character stream nest
// properly, one string at a time, with the last word of each string marked.
// ============================================================================
module bracket_balance_checker_top
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbc_in_if.sink    i_in,
    bbc_out_if.source o_out
);

    // The front end classifies each accepted word into a push, a pop or
    // nothing and places it in a two-entry queue. The queue's fill count is
    // registered, so input ready never depends on the output side in the
    // same cycle.
    logic q_full;
    logic q_wr;
    t_op  q_wr_op;
    logic q_valid;
    t_op  q_op;
    logic q_rd;

    bbc_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_wr   (q_wr),
        .o_q_op   (q_wr_op)
    );

    bbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wr_op (q_wr_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_rd    (q_rd)
    );

    // The stack engine takes one queued operation per cycle. An operation
    // that ends a string waits only when the verdict register is still
    // occupied and not being taken; all other operations never wait.
    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_op    (q_op),
        .o_q_rd    (q_rd),
        .o_out     (o_out)
    );

endmodule

// File: sim/bbc_verdict_monitor.sv
// ============================================================================
// bbc_verdict_monitor : nesting tracker and verdict checker
// Watches the character and verdict channels of the bracket balance checker.
// It keeps its own bracket stack to work out the verdict due for each string
// and compares every verdict the block hands out against the oldest one due.
// ============================================================================
module bbc_verdict_monitor
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bbc_in_if    i_chars,
    bbc_out_if   i_verdicts,
    output int   o_fail_count,
    output int   o_verdicts_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);

    typedef struct packed {
        logic balanced;
        logic overflowed;
    } t_verdict;

    t_code          nest_codes [STACK_DEPTH];
    logic [LEVEL_W-1:0] nest_level;
    logic           nest_failed;
    logic           nest_overflow;
    t_verdict       verdicts_due [$];
    int             fail_count = 0;

    function automatic t_code opener_code(input logic [7:0] ch);
        case (ch)
            CH_OPEN_ROUND:  return CODE_ROUND;
            CH_OPEN_CURLY:  return CODE_CURLY;
            CH_OPEN_SQUARE: return CODE_SQUARE;
            default:        return CODE_NONE;
        endcase
    endfunction

    function automatic t_code closer_code(input logic [7:0] ch);
        case (ch)
            CH_CLOSE_ROUND:  return CODE_ROUND;
            CH_CLOSE_CURLY:  return CODE_CURLY;
            CH_CLOSE_SQUARE: return CODE_SQUARE;
            default:         return CODE_NONE;
        endcase
    endfunction

    // Applies one accepted word to the tracked nesting and, on the last word
    // of a string, queues the verdict due and clears the string state.
    task automatic track_word(input logic [7:0] ch, input logic last);
        t_code    opened;
        t_code    closed;
        t_verdict due;
        opened = opener_code(ch);
        closed = closer_code(ch);
        // Once a string has failed, its stack stays frozen until the end.
        if (!nest_failed) begin
            if (opened != CODE_NONE) begin
                if (nest_level == STACK_DEPTH) begin
                    nest_failed   = 1'b1;
                    nest_overflow = 1'b1;
                end else begin
                    nest_codes[nest_level] = opened;
                    nest_level = nest_level + 1'b1;
                end
            end else if (closed != CODE_NONE) begin
                if (nest_level == 0 || nest_codes[nest_level - 1'b1] != closed) begin
                    nest_failed = 1'b1;
                end else begin
                    nest_level = nest_level - 1'b1;
                end
            end
        end
        if (last) begin
            due.balanced   = !nest_failed && (nest_level == 0);
            due.overflowed = nest_overflow;
            verdicts_due.push_back(due);
            nest_level    = '0;
            nest_failed   = 1'b0;
            nest_overflow = 1'b0;
        end
    endtask

    task automatic check_verdict(input logic balanced, input logic overflowed);
        t_verdict due;
        if (verdicts_due.size() == 0) begin
            $error("verdict with none due: balanced=%0b overflowed=%0b",
                   balanced, overflowed);
            fail_count++;
        end else begin
            due = verdicts_due.pop_front();
            if (balanced !== due.balanced) begin
                $error("balanced: expected %0b, actual %0b", due.balanced, balanced);
                fail_count++;
            end
            if (overflowed !== due.overflowed) begin
                $error("overflowed: expected %0b, actual %0b", due.overflowed, overflowed);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            nest_level    = '0;
            nest_failed   = 1'b0;
            nest_overflow = 1'b0;
            verdicts_due.delete();
        end else begin
            if (i_chars.valid && i_chars.ready) begin
                track_word(i_chars.ch, i_chars.last);
            end
            if (i_verdicts.valid && i_verdicts.ready) begin
                check_verdict(i_verdicts.balanced, i_verdicts.overflowed);
            end
        end
        o_fail_count   <= fail_count;
        o_verdicts_due <= verdicts_due.size();
    end

endmodule

// File: sim/bracket_balance_checker_top_tb.sv
// ============================================================================
// bracket_balance_checker_top_tb : testbench of the bracket balance checker
// Feeds strings of character words, first a handful of hand-picked cases and
// then random well-formed, broken, noisy and very deep strings, with random
// gaps on both channels. A verdict monitor beside the block checks every
// verdict; this module gives the overall verdict of the run.
// ============================================================================
module bracket_balance_checker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bbc_pkg::*;

    localparam int STACK_DEPTH     = 64;
    localparam int WORD_TARGET     = 1250;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 20;

    logic i_clk;
    logic i_rst_n;

    bbc_in_if  chars_if ();
    bbc_out_if verdicts_if ();

    int   fail_count;
    int   verdicts_due;
    int   words_sent = 0;
    // When set, neither side inserts random gaps.
    logic steady;
    // Asks the verdict side for its single long hold-off.
    logic hold_go;
    bit   hold_done = 1'b0;

    // The string being assembled before it is sent.
    logic [7:0] text [$];

    bracket_balance_checker_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (chars_if),
        .o_out   (verdicts_if)
    );

    bbc_verdict_monitor #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_chars        (chars_if),
        .i_verdicts     (verdicts_if),
        .o_fail_count   (fail_count),
        .o_verdicts_due (verdicts_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Helpers for building strings. Brackets are always written through the
    // package names so that the byte values live in one place.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] opener_of(input t_code code);
        case (code)
            CODE_ROUND: return CH_OPEN_ROUND;
            CODE_CURLY: return CH_OPEN_CURLY;
            default:    return CH_OPEN_SQUARE;
        endcase
    endfunction

    function automatic logic [7:0] closer_of(input t_code code);
        case (code)
            CODE_ROUND: return CH_CLOSE_ROUND;
            CODE_CURLY: return CH_CLOSE_CURLY;
            default:    return CH_CLOSE_SQUARE;
        endcase
    endfunction

    function automatic t_code random_kind();
        case ($urandom_range(0, 2))
            0:       return CODE_ROUND;
            1:       return CODE_CURLY;
            default: return CODE_SQUARE;
        endcase
    endfunction

    function automatic logic [7:0] random_bracket();
        if ($urandom_range(0, 1) == 0) begin
            return opener_of(random_kind());
        end
        return closer_of(random_kind());
    endfunction

    function automatic bit is_bracket(input logic [7:0] ch);
        case (ch)
            CH_OPEN_ROUND, CH_OPEN_CURLY, CH_OPEN_SQUARE,
            CH_CLOSE_ROUND, CH_CLOSE_CURLY, CH_CLOSE_SQUARE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Any byte other than a bracket; the block should pass straight over it.
    function automatic logic [7:0] noise_byte();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        while (is_bracket(ch)) begin
            ch = 8'($urandom_range(0, 255));
        end
        return ch;
    endfunction

    // A properly nested string with noise in between, never deeper than
    // max_depth. Whatever is still open at the end is closed in order.
    task automatic compose_nested(input int steps, input int max_depth);
        t_code open_kinds [$];
        int    pick;
        text.delete();
        repeat (steps) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 && open_kinds.size() < max_depth) begin
                open_kinds.push_back(random_kind());
                text.push_back(opener_of(open_kinds[$]));
            end else if (pick < 75 && open_kinds.size() > 0) begin
                text.push_back(closer_of(open_kinds.pop_back()));
            end else begin
                text.push_back(noise_byte());
            end
        end
        while (open_kinds.size() > 0) begin
            text.push_back(closer_of(open_kinds.pop_back()));
        end
        if (text.size() == 0) begin
            text.push_back(noise_byte());
        end
    endtask

    // Spoils the string at one random place: a bracket is swapped in, one
    // word is dropped, or a stray bracket is inserted. This need not break it.
    task automatic spoil_text();
        int idx;
        idx = $urandom_range(0, text.size() - 1);
        case ($urandom_range(0, 2))
            0: text[idx] = random_bracket();
            1: begin
                if (text.size() > 1) begin
                    text.delete(idx);
                end else begin
                    text[idx] = random_bracket();
                end
            end
            default: text.insert(idx, random_bracket());
        endcase
    endtask

    // Raw bytes, half of them brackets, so that every bit pattern turns up.
    task automatic compose_jumble(input int len);
        text.delete();
        repeat (len) begin
            if ($urandom_range(0, 1) == 0) begin
                text.push_back(8'($urandom_range(0, 255)));
            end else begin
                text.push_back(random_bracket());
            end
        end
    endtask

    // Deep nesting: an optional leading stray closer, a run of openers and
    // then closers that match from the top down for as long as any are open.
    task automatic compose_deep(input int opens, input bit stray_first, input int closes);
        t_code open_kinds [$];
        text.delete();
        if (stray_first) begin
            text.push_back(closer_of(random_kind()));
        end
        repeat (opens) begin
            open_kinds.push_back(random_kind());
            text.push_back(opener_of(open_kinds[$]));
        end
        repeat (closes) begin
            if (open_kinds.size() > 0) begin
                text.push_back(closer_of(open_kinds.pop_back()));
            end else begin
                text.push_back(closer_of(random_kind()));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Character side. A word is offered until the block takes it; a random
    // one-cycle gap may come before each word unless the run is in its
    // steady stretch.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [7:0] ch, input logic last);
        if (!steady && $urandom_range(0, 99) < 25) begin
            chars_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.ch    <= ch;
        chars_if.last  <= last;
        @(posedge i_clk);
        while (!chars_if.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_text();
        foreach (text[i]) begin
            send_word(text[i], i == text.size() - 1);
        end
    endtask

    // Stops offering words until every verdict due has come back. The first
    // edge lets the monitor see the final word before its count is read.
    task automatic wait_drained();
        chars_if.valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_due != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Verdict side. It stalls at random, except in the steady stretch, and
    // once holds off for a long stretch so that the block backs up and has
    // to refuse words.
    // ------------------------------------------------------------------------
    initial begin
        verdicts_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                verdicts_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                verdicts_if.ready <= steady || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: the run is abandoned if nothing moves on either channel for
    // far longer than the longest deliberate hold-off.
    // ------------------------------------------------------------------------
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((chars_if.valid && chars_if.ready) ||
                (verdicts_if.valid && verdicts_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int  pick;
        bit  paused_once;
        paused_once = 1'b0;

        i_rst_n        <= 1'b0;
        chars_if.valid <= 1'b0;
        chars_if.ch    <= '0;
        chars_if.last  <= 1'b0;
        steady         <= 1'b0;
        hold_go        <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Hand-picked strings. Single bytes at both ends of the range, with
        // no bracket at all, must come out balanced.
        text = '{8'h00};
        send_text();
        text = '{8'hFF};
        send_text();
        text = '{CH_OPEN_ROUND, CH_CLOSE_ROUND};
        send_text();
        text = '{CH_OPEN_CURLY, CH_OPEN_SQUARE, CH_OPEN_ROUND,
                 CH_CLOSE_ROUND, CH_CLOSE_SQUARE, CH_CLOSE_CURLY};
        send_text();
        // A closer with nothing open.
        text = '{CH_CLOSE_SQUARE};
        send_text();
        // A closer of the wrong kind for the bracket on top.
        text = '{CH_OPEN_ROUND, CH_CLOSE_CURLY};
        send_text();
        // After a failure the stack is frozen, so the later pair must not
        // rescue the string.
        text = '{CH_CLOSE_ROUND, CH_OPEN_ROUND, CH_CLOSE_ROUND};
        send_text();
        // A string that ends with a bracket still open.
        text = '{CH_OPEN_SQUARE};
        send_text();
        // Noise inside and after a pair; the two noise bytes flip every bit.
        text = '{CH_OPEN_CURLY, 8'h55, CH_CLOSE_CURLY, 8'hAA};
        send_text();
        wait_drained();

        // The depth extremes: exactly full and then emptied, a push onto the
        // full stack on the last word, a failure that hides a later overflow,
        // a closer once the stack is emptied again, and closers after overflow.
        compose_deep(STACK_DEPTH, 1'b0, STACK_DEPTH);
        send_text();
        compose_deep(STACK_DEPTH + 1, 1'b0, 0);
        send_text();
        compose_deep(STACK_DEPTH + 2, 1'b1, 3);
        send_text();
        compose_deep(STACK_DEPTH, 1'b0, STACK_DEPTH + 1);
        send_text();
        compose_deep(STACK_DEPTH + 3, 1'b0, STACK_DEPTH);
        send_text();
        wait_drained();

        // Random strings, mostly well formed so that the stack is exercised
        // in depth, with spoilt strings and raw jumble mixed in.
        while (words_sent < WORD_TARGET) begin
            if (words_sent >= 600 && !hold_go) begin
                hold_go <= 1'b1;
            end
            steady <= (words_sent >= 850 && words_sent < 1050);
            if (words_sent >= 750 && !paused_once) begin
                paused_once = 1'b1;
                wait_drained();
            end

            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                compose_nested($urandom_range(1, 20), $urandom_range(1, 8));
            end else if (pick < 60) begin
                compose_nested($urandom_range(20, 60), $urandom_range(8, STACK_DEPTH));
            end else if (pick < 80) begin
                compose_nested($urandom_range(1, 20), $urandom_range(1, 8));
                spoil_text();
            end else begin
                compose_jumble($urandom_range(1, 12));
            end
            send_text();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/bbc_pkg.sv
rtl/bbc_ifs.sv
rtl/bbc_front.sv
rtl/bbc_queue.sv
rtl/bbc_back.sv
rtl/bracket_balance_checker_top.sv
sim/bbc_verdict_monitor.sv
sim/bracket_balance_checker_top_tb.sv
